### rtl/mpwc_pkg.sv
// Package for the multichannel pulse-width capture block.
// Holds the beat payload types, operation codes and fixed constants.
// No dependencies.
`default_nettype none

package mpwc_pkg;

  // Operation codes carried in the op field of an input beat.
  localparam logic [2:0] OP_SAMPLE      = 3'd0;
  localparam logic [2:0] OP_LONG_TICK   = 3'd1;
  localparam logic [2:0] OP_SHORT_TICK  = 3'd2;
  localparam logic [2:0] OP_READ_START  = 3'd3;
  localparam logic [2:0] OP_READ_NEXT   = 3'd4;

  // Link byte reported when the link was seen alive during the last period.
  localparam logic [7:0] LINK_ALIVE_CODE = 8'h11;

  // Widest pin bus and timer.
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned TIME_W       = 16;

  // Input beat.
  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        pins;
    logic [TIME_W-1:0] time_now;
  } sample_item_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] read_data;
    logic       pulse_out;
    logic       link_led;
    logic       link_lost;
  } result_item_t;

  // Level outputs after an operation has been applied.
  typedef struct packed {
    logic pulse_level;
    logic led_level;
    logic link_lost;
  } capture_status_t;

endpackage

`default_nettype wire

### rtl/mpwc_capture.sv
// Edge detection, start-time and width capture, link and pulse state.
// Depends on mpwc_pkg.
`default_nettype none

module mpwc_capture #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         fire,
  input  mpwc_pkg::sample_item_t      item,
  output logic [mpwc_pkg::TIME_W-1:0] widths [CHANNELS],
  output logic [7:0]                  link_byte,
  output mpwc_pkg::capture_status_t   status_next
);
  import mpwc_pkg::*;

  logic [CHANNELS-1:0] previous_pins;
  logic [TIME_W-1:0]   start_time [CHANNELS];
  logic                link_lost;
  logic                led_level;
  logic                pulse_level;

  logic                is_sample;
  logic                is_long;
  logic [CHANNELS-1:0] changed;
  logic [CHANNELS-1:0] rise;
  logic [CHANNELS-1:0] fall;
  logic [7:0]          link_byte_next;

  // Per-channel edges, only meaningful on a pin sample.
  assign is_sample = (item.op == OP_SAMPLE);
  assign is_long   = (item.op == OP_LONG_TICK);
  assign changed   = is_sample ? (item.pins[CHANNELS-1:0] ^ previous_pins) : '0;
  assign rise      = changed & item.pins[CHANNELS-1:0];
  assign fall      = changed & ~item.pins[CHANNELS-1:0];

  // Next values of the link and pulse levels.
  always_comb begin
    status_next.pulse_level = pulse_level;
    status_next.led_level   = led_level;
    status_next.link_lost   = link_lost;
    link_byte_next          = link_byte;
    if (is_sample) begin
      if (rise[0] || (|fall)) begin
        status_next.pulse_level = 1'b1;
      end
      if (rise[0]) begin
        status_next.link_lost = 1'b0;
      end
    end else if (is_long) begin
      if (!link_lost) begin
        link_byte_next        = LINK_ALIVE_CODE;
        status_next.led_level = 1'b0;
        status_next.link_lost = 1'b1;
      end else begin
        link_byte_next        = '0;
        status_next.led_level = 1'b1;
      end
    end else if (item.op == OP_SHORT_TICK) begin
      status_next.pulse_level = 1'b0;
    end
  end

  // State update, one operation per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins <= '0;
      link_lost     <= 1'b0;
      led_level     <= 1'b1;
      pulse_level   <= 1'b0;
      link_byte     <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        start_time[c] <= '0;
        widths[c]     <= '0;
      end
    end else if (fire) begin
      link_lost   <= status_next.link_lost;
      led_level   <= status_next.led_level;
      pulse_level <= status_next.pulse_level;
      link_byte   <= link_byte_next;
      if (is_sample) begin
        previous_pins <= item.pins[CHANNELS-1:0];
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (rise[c]) begin
          start_time[c] <= item.time_now;
        end
        if (fall[c]) begin
          widths[c] <= item.time_now - start_time[c];
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/mpwc_readout.sv
// Byte-serial readout of the width map, battery bytes and link byte.
// Depends on mpwc_pkg.
`default_nettype none

module mpwc_readout #(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned BATTERY_BYTES = 4
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         fire,
  input  wire  [2:0]                  op,
  input  wire  [mpwc_pkg::TIME_W-1:0] widths [CHANNELS],
  input  wire  [7:0]                  link_byte,
  output logic [7:0]                  read_data
);
  import mpwc_pkg::*;

  localparam int unsigned MAP_LENGTH = 2 * CHANNELS + BATTERY_BYTES + 1;
  localparam int unsigned PTR_W      = $clog2(MAP_LENGTH + 1);
  localparam logic [PTR_W-1:0] WIDTH_END = PTR_W'(2 * CHANNELS);
  localparam logic [PTR_W-1:0] LINK_ADDR = PTR_W'(2 * CHANNELS + BATTERY_BYTES);
  localparam logic [PTR_W-1:0] MAP_END   = PTR_W'(MAP_LENGTH);

  logic [PTR_W-1:0] read_pointer;
  logic [PTR_W-1:0] read_pointer_next;
  logic [PTR_W-1:0] addr;
  logic             is_read;
  logic [7:0]       map_byte;

  assign is_read = (op == OP_READ_START) || (op == OP_READ_NEXT);
  assign addr    = (op == OP_READ_START) ? '0 : read_pointer;

  // Byte at the current address; everything past the link byte reads zero.
  always_comb begin
    map_byte = '0;
    if (addr < WIDTH_END) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (addr[PTR_W-1:1] == (PTR_W-1)'(c)) begin
          map_byte = addr[0] ? widths[c][15:8] : widths[c][7:0];
        end
      end
    end else if (addr == LINK_ADDR) begin
      map_byte = link_byte;
    end
  end

  assign read_data         = is_read ? map_byte : '0;
  assign read_pointer_next = (addr < MAP_END) ? addr + 1'b1 : addr;

  // Pointer advances on each read and saturates at the map length.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer <= '0;
    end else if (fire && is_read) begin
      read_pointer <= read_pointer_next;
    end
  end

endmodule

`default_nettype wire

### rtl/multichannel_pulse_width_capture.sv
// Multichannel pulse-width capture, top level.
// Input register, capture and readout logic, and the result register.
// Depends on mpwc_pkg, mpwc_capture and mpwc_readout.
//
// Usage: the sample channel takes one beat per operation (pin sample, long
// tick, short tick, read start, read next). Every beat accepted yields exactly
// one beat on the result channel, in order: the read byte (zero for non-read
// operations) and the pulse, LED and link-lost levels after that operation.
// A beat is held in the input register, its operation is applied to the channel
// state, and its result is loaded into the result register. Throughput is one
// beat per clock while result_ready stays high. While the receiver stalls, the
// result register holds its beat and the input register still accepts one more
// beat; after that sample_ready drops until the result is taken. Synchronous
// reset clears all start times, widths, the read pointer and link state, sets
// the LED level high and empties both registers.
`default_nettype none

module multichannel_pulse_width_capture #(
  parameter int unsigned CHANNELS      = 8,
  parameter int unsigned BATTERY_BYTES = 4
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     sample_valid,
  output logic                    sample_ready,
  input  mpwc_pkg::sample_item_t  sample,
  output logic                    result_valid,
  input  wire                     result_ready,
  output mpwc_pkg::result_item_t  result
);
  import mpwc_pkg::*;

  logic            stage_valid;
  sample_item_t    stage_item;
  logic            advance;
  logic [TIME_W-1:0] widths [CHANNELS];
  logic [7:0]      link_byte;
  capture_status_t status_next;
  logic [7:0]      read_data;

  // The staged beat moves on when the result register is free or being drained.
  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage_item <= sample;
    end
  end

  mpwc_capture #(
    .CHANNELS (CHANNELS)
  ) u_capture (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .item        (stage_item),
    .widths      (widths),
    .link_byte   (link_byte),
    .status_next (status_next)
  );

  mpwc_readout #(
    .CHANNELS      (CHANNELS),
    .BATTERY_BYTES (BATTERY_BYTES)
  ) u_readout (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .op        (stage_item.op),
    .widths    (widths),
    .link_byte (link_byte),
    .read_data (read_data)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.read_data <= read_data;
      result.pulse_out <= status_next.pulse_level;
      result.link_led  <= status_next.led_level;
      result.link_lost <= status_next.link_lost;
    end
  end

endmodule

`default_nettype wire
